[src/cbik_pkg.sv]
// cbik_pkg: shared types, codes and tables for the cartridge bank / irq / kanji register block
// depends on nothing; used by the channel interfaces and the core
package cbik_pkg;

    // request command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // register window and glyph port addresses
    localparam logic [3:0]  REG_WINDOW = 4'hD;
    localparam logic [15:0] ADDR_GLYPH_TILE = 16'hDC00;
    localparam logic [15:0] ADDR_GLYPH_BANK = 16'hDD00;

    // register indexes inside the window
    localparam logic [3:0] REG_RAM_6000   = 4'd0;
    localparam logic [3:0] REG_RAM_7000   = 4'd1;
    localparam logic [3:0] REG_PRG_8000   = 4'd2;
    localparam logic [3:0] REG_PRG_A000   = 4'd3;
    localparam logic [3:0] REG_PRG_C000   = 4'd4;
    localparam logic [3:0] REG_CHR_LOW    = 4'd5;
    localparam logic [3:0] REG_IRQ_LO     = 4'd6;
    localparam logic [3:0] REG_IRQ_HI     = 4'd7;
    localparam logic [3:0] REG_IRQ_ACK    = 4'd8;
    localparam logic [3:0] REG_IRQ_CTRL   = 4'd9;
    localparam logic [3:0] REG_MODE       = 4'd10;
    localparam logic [3:0] REG_GLYPH_BANK = 4'd11;
    localparam logic [3:0] REG_JIS_COL    = 4'd12;
    localparam logic [3:0] REG_JIS_ROW    = 4'd13;

    localparam int          NUM_REGS  = 16;
    localparam logic [7:0]  JIS_BASE  = 8'h20;
    localparam logic [7:0]  JIS_LIMIT = 8'h60;
    localparam logic [6:0]  PRG_HIGH_BASE = 7'h10;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_hit;
        logic       irq_line;
        logic [6:0] prg_bank_8000;
        logic [6:0] prg_bank_a000;
        logic [6:0] prg_bank_c000;
        logic       ram_bank_6000;
        logic       ram_bank_7000;
        logic       chr_bank_low;
        logic       mirror_horizontal;
        logic       font_mode;
    } rsp_t;

    // font page lookup, 36 page indexes onto 16 font pages
    function automatic logic [3:0] page_of(input logic [5:0] idx);
        logic [3:0] pg;
        case (idx)
            6'd0:  pg = 4'h0;  6'd1:  pg = 4'h0;  6'd2:  pg = 4'h2;  6'd3:  pg = 4'h2;
            6'd4:  pg = 4'h1;  6'd5:  pg = 4'h1;  6'd6:  pg = 4'h4;  6'd7:  pg = 4'h5;
            6'd8:  pg = 4'h6;  6'd9:  pg = 4'h7;  6'd10: pg = 4'h8;  6'd11: pg = 4'h9;
            6'd12: pg = 4'hA;  6'd13: pg = 4'hB;  6'd14: pg = 4'hC;  6'd15: pg = 4'hD;
            6'd16: pg = 4'hE;  6'd17: pg = 4'hF;  6'd18: pg = 4'h0;  6'd19: pg = 4'h1;
            6'd20: pg = 4'h2;  6'd21: pg = 4'h3;  6'd22: pg = 4'h4;  6'd23: pg = 4'h5;
            6'd24: pg = 4'h6;  6'd25: pg = 4'h7;  6'd26: pg = 4'h8;  6'd27: pg = 4'h9;
            6'd28: pg = 4'hA;  6'd29: pg = 4'hB;  6'd30: pg = 4'hC;  6'd31: pg = 4'hD;
            6'd32: pg = 4'hE;  6'd33: pg = 4'hF;  6'd34: pg = 4'hD;  6'd35: pg = 4'hD;
            default: pg = 4'h0;
        endcase
        return pg;
    endfunction

    // 8 KiB rom bank from a bank register
    function automatic logic [6:0] prg_bank_of(input logic [7:0] r);
        logic [6:0] b;
        if (r[6])
        begin
            b = {1'b0, r[5:0]} + PRG_HIGH_BASE;
        end
        else
        begin
            b = {3'b000, r[3:0]};
        end
        return b;
    endfunction

endpackage

[src/cbik_in_if.sv]
// cbik_in_if: request channel (cmd, address, write_data) with valid/ready
// depends on cbik_pkg
interface cbik_in_if;
    logic            valid;
    logic            ready;
    cbik_pkg::req_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/cbik_out_if.sv]
// cbik_out_if: result channel (read data, irq line, bank and mode outputs) with valid/ready
// depends on cbik_pkg
interface cbik_out_if;
    logic            valid;
    logic            ready;
    cbik_pkg::rsp_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/cartridge_bank_irq_kanji_regs_core.sv]
// cartridge_bank_irq_kanji_regs_core: mapper register file, tick-driven irq counter, kanji glyph port
// depends on cbik_pkg, cbik_in_if, cbik_out_if
//
//  channel   | dir | payload                                   | handshake
//  ----------+-----+-------------------------------------------+-----------
//  req_ch    | in  | cmd, address, write_data                  | valid/ready
//  rsp_ch    | out | read_data, read_hit, irq_line, banks, mode | valid/ready
//
// one request per clock while req_ch.ready is high; its state update lands at the accepting edge and its result
// sits in the result register from the next cycle on
// req_ch.ready is high while the result register is empty or being taken this cycle
// a stall on rsp_ch holds one result and stops requests, nothing is dropped
// rst_n clears the registers, the irq counter and the result valid
module cartridge_bank_irq_kanji_regs_core (
    input  logic        clk,
    input  logic        rst_n,
    cbik_in_if.sink     req_ch,
    cbik_out_if.source  rsp_ch
);

    logic [7:0]   regs_reg [cbik_pkg::NUM_REGS];
    logic [7:0]   regs_next [cbik_pkg::NUM_REGS];
    logic         irq_after_reg, irq_after_next;
    logic         irq_enable_reg, irq_enable_next;
    logic [15:0]  irq_count_reg, irq_count_next;
    logic [15:0]  irq_reload_reg, irq_reload_next;
    logic         irq_pending_reg, irq_pending_next;

    logic            out_valid_reg;
    cbik_pkg::rsp_t  out_data_reg;
    cbik_pkg::rsp_t  rsp_next;

    logic         accept;
    logic [3:0]   reg_idx;
    logic         in_window;
    logic [7:0]   wdata;
    logic [15:0]  addr;
    logic [15:0]  count_inc;

    // glyph path signals
    logic [7:0]   row;
    logic [7:0]   col;
    logic [5:0]   page_idx;
    logic [3:0]   page;
    logic         glyph_hit;
    logic         code_ok;
    logic [7:0]   glyph_data;

    assign req_ch.ready  = !out_valid_reg || rsp_ch.ready;
    assign accept        = req_ch.valid && req_ch.ready;
    assign addr          = req_ch.payload.address;
    assign wdata         = req_ch.payload.write_data;
    assign reg_idx       = addr[11:8];
    assign in_window     = (addr[15:12] == cbik_pkg::REG_WINDOW);
    assign count_inc     = irq_count_reg + 16'd1;

    // state update for one request
    always_comb
    begin
        for (int i = 0; i < cbik_pkg::NUM_REGS; i++)
        begin
            regs_next[i] = regs_reg[i];
        end
        irq_after_next   = irq_after_reg;
        irq_enable_next  = irq_enable_reg;
        irq_count_next   = irq_count_reg;
        irq_reload_next  = irq_reload_reg;
        irq_pending_next = irq_pending_reg;
        if (accept)
        begin
            if (req_ch.payload.cmd == cbik_pkg::CMD_TICK)
            begin
                if (irq_enable_reg)
                begin
                    if (count_inc == 16'd0)
                    begin
                        irq_count_next   = irq_reload_reg;
                        irq_pending_next = 1'b1;
                    end
                    else
                    begin
                        irq_count_next = count_inc;
                    end
                end
            end
            else if (req_ch.payload.cmd == cbik_pkg::CMD_WRITE && in_window)
            begin
                regs_next[reg_idx] = wdata;
                unique case (reg_idx)
                    cbik_pkg::REG_IRQ_LO:
                    begin
                        irq_reload_next = {irq_reload_reg[15:8], wdata};
                    end
                    cbik_pkg::REG_IRQ_HI:
                    begin
                        irq_reload_next = {wdata, irq_reload_reg[7:0]};
                    end
                    cbik_pkg::REG_IRQ_ACK:
                    begin
                        irq_enable_next  = irq_after_reg;
                        irq_pending_next = 1'b0;
                    end
                    cbik_pkg::REG_IRQ_CTRL:
                    begin
                        irq_after_next   = wdata[0];
                        irq_enable_next  = wdata[1];
                        if (wdata[1])
                        begin
                            irq_count_next = irq_reload_reg;
                        end
                        irq_pending_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // kanji glyph address from jis row and column
    always_comb
    begin
        row       = regs_reg[cbik_pkg::REG_JIS_ROW] - cbik_pkg::JIS_BASE;
        col       = regs_reg[cbik_pkg::REG_JIS_COL] - cbik_pkg::JIS_BASE;
        code_ok   = (row < cbik_pkg::JIS_LIMIT) && (col < cbik_pkg::JIS_LIMIT);
        // page_idx = row bit 3 + 2 * col/32 + 6 * row/16
        page_idx  = {5'd0, row[3]} + {3'd0, col[6:5], 1'b0}
                  + {1'b0, row[6:4], 2'b00} + {2'b00, row[6:4], 1'b0};
        page      = cbik_pkg::page_of(page_idx);
        glyph_hit = (req_ch.payload.cmd == cbik_pkg::CMD_READ)
                 && (addr == cbik_pkg::ADDR_GLYPH_TILE || addr == cbik_pkg::ADDR_GLYPH_BANK);
        glyph_data = 8'h00;
        if (glyph_hit && code_ok)
        begin
            if (addr == cbik_pkg::ADDR_GLYPH_TILE)
            begin
                glyph_data = {row[0], col[4:0], regs_reg[cbik_pkg::REG_GLYPH_BANK][1:0]};
            end
            else
            begin
                glyph_data = {regs_reg[cbik_pkg::REG_GLYPH_BANK][2], 1'b1, page, row[2:1]};
            end
        end
    end

    // result after the request has taken effect
    always_comb
    begin
        rsp_next.read_data         = glyph_data;
        rsp_next.read_hit          = glyph_hit;
        rsp_next.irq_line          = irq_pending_next;
        rsp_next.prg_bank_8000     = cbik_pkg::prg_bank_of(regs_next[cbik_pkg::REG_PRG_8000]);
        rsp_next.prg_bank_a000     = cbik_pkg::prg_bank_of(regs_next[cbik_pkg::REG_PRG_A000]);
        rsp_next.prg_bank_c000     = cbik_pkg::prg_bank_of(regs_next[cbik_pkg::REG_PRG_C000]);
        rsp_next.ram_bank_6000     = regs_next[cbik_pkg::REG_RAM_6000][0];
        rsp_next.ram_bank_7000     = regs_next[cbik_pkg::REG_RAM_7000][0];
        rsp_next.chr_bank_low      = regs_next[cbik_pkg::REG_CHR_LOW][0];
        rsp_next.mirror_horizontal = regs_next[cbik_pkg::REG_MODE][1];
        rsp_next.font_mode         = regs_next[cbik_pkg::REG_MODE][0];
    end

    // mapper state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cbik_pkg::NUM_REGS; i++)
            begin
                regs_reg[i] <= 8'h00;
            end
            irq_after_reg   <= 1'b0;
            irq_enable_reg  <= 1'b0;
            irq_count_reg   <= 16'h0000;
            irq_reload_reg  <= 16'h0000;
            irq_pending_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < cbik_pkg::NUM_REGS; i++)
            begin
                regs_reg[i] <= regs_next[i];
            end
            irq_after_reg   <= irq_after_next;
            irq_enable_reg  <= irq_enable_next;
            irq_count_reg   <= irq_count_next;
            irq_reload_reg  <= irq_reload_next;
            irq_pending_reg <= irq_pending_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= rsp_next;
        end
    end

    assign rsp_ch.valid   = out_valid_reg;
    assign rsp_ch.payload = out_data_reg;

endmodule
